[rtl/core/fdd_pkg.sv]
// ----------------------------------------------------------------------------
// fdd_pkg: shared types and constants for the demixing MAC
// Sample, sum and index widths, configuration register codes and reset values,
// and the sequencer status bundle.
// ----------------------------------------------------------------------------
package fdd_pkg;

  // Payload widths
  localparam int SAMPLE_W  = 16;   // Q1.15 spectrum and weight parts
  localparam int PROD_W    = 32;   // one real 16x16 product
  localparam int SUM_W     = 37;   // Q7.30 sum with guard bits
  localparam int SRC_IDX_W = 2;
  localparam int BIN_IDX_W = 10;

  // Parameter defaults
  localparam int DEF_MAX_SOURCES  = 4;
  localparam int DEF_MAX_CHANNELS = 16;
  localparam int DEF_MAX_BINS     = 1024;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int SRC_CFG_W  = 3;
  localparam int CH_CFG_W   = 5;
  localparam int BIN_CFG_W  = 11;

  localparam logic [SRC_CFG_W-1:0] SRC_CFG_RST = SRC_CFG_W'(4);
  localparam logic [CH_CFG_W-1:0]  CH_CFG_RST  = CH_CFG_W'(4);
  localparam logic [BIN_CFG_W-1:0] BIN_CFG_RST = BIN_CFG_W'(257);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCES  = 2'd0,
    CFG_CHANNELS = 2'd1,
    CFG_BINS     = 2'd2
  } cfg_reg_e;

  // Position of the item in stage 1 within the frame
  typedef struct packed {
    logic                 last_ch;     // final channel of the bin
    logic                 last_frame;  // final bin of the final source
    logic                 frame_start; // source 0, bin 0, channel 0
    logic [SRC_IDX_W-1:0] src_idx;
    logic [BIN_IDX_W-1:0] bin_idx;
  } seq_t;

endpackage

[rtl/core/fdd_if.sv]
// ----------------------------------------------------------------------------
// fdd_if: valid/ready channels of the demixing MAC
// fdd_in_if carries one channel sample and weight, fdd_out_if one separated
// bin.
// ----------------------------------------------------------------------------
interface fdd_in_if import fdd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] x_re;
  logic signed [SAMPLE_W-1:0] x_im;
  logic signed [SAMPLE_W-1:0] w_re;
  logic signed [SAMPLE_W-1:0] w_im;
  logic                       channel_enabled;
  logic                       source_active;

  modport source (
    output valid, x_re, x_im, w_re, w_im, channel_enabled, source_active,
    input  ready
  );
  modport sink (
    input  valid, x_re, x_im, w_re, w_im, channel_enabled, source_active,
    output ready
  );
endinterface

interface fdd_out_if import fdd_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [SUM_W-1:0]     y_re;
  logic signed [SUM_W-1:0]     y_im;
  logic        [SRC_IDX_W-1:0] source_index;
  logic        [BIN_IDX_W-1:0] bin_index;
  logic                        last_of_frame;

  modport source (
    output valid, y_re, y_im, source_index, bin_index, last_of_frame,
    input  ready
  );
  modport sink (
    input  valid, y_re, y_im, source_index, bin_index, last_of_frame,
    output ready
  );
endinterface

[rtl/core/fdd_seq.sv]
// ----------------------------------------------------------------------------
// fdd_seq: frame sequencer
// Holds the configuration registers and the channel, bin and source counters;
// flags the last channel of a bin and the last bin of a frame.
// ----------------------------------------------------------------------------
module fdd_seq import fdd_pkg::*; #(
  parameter int MAX_SOURCES  = DEF_MAX_SOURCES,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_BINS     = DEF_MAX_BINS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  adv_i,
  output seq_t                  seq_o
);

  localparam int SRC_W  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int NSRC_W = $clog2(MAX_SOURCES + 1);
  localparam int NCH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int NBIN_W = $clog2(MAX_BINS + 1);

  logic [SRC_CFG_W-1:0] src_cfg_q;
  logic [CH_CFG_W-1:0]  ch_cfg_q;
  logic [BIN_CFG_W-1:0] bin_cfg_q;

  logic [SRC_W-1:0] src_cnt_q, src_cnt_d;
  logic [CH_W-1:0]  ch_cnt_q, ch_cnt_d;
  logic [BIN_W-1:0] bin_cnt_q, bin_cnt_d;

  logic [NSRC_W-1:0] n_src;
  logic [NCH_W-1:0]  n_ch;
  logic [NBIN_W-1:0] n_bin;
  logic              last_src, last_bin, last_ch;

  // Clamp each register to 1..max; zero acts as one
  always_comb begin
    if (src_cfg_q == '0) begin
      n_src = NSRC_W'(1);
    end else if (32'(src_cfg_q) > 32'(MAX_SOURCES)) begin
      n_src = NSRC_W'(MAX_SOURCES);
    end else begin
      n_src = NSRC_W'(src_cfg_q);
    end

    if (ch_cfg_q == '0) begin
      n_ch = NCH_W'(1);
    end else if (32'(ch_cfg_q) > 32'(MAX_CHANNELS)) begin
      n_ch = NCH_W'(MAX_CHANNELS);
    end else begin
      n_ch = NCH_W'(ch_cfg_q);
    end

    if (bin_cfg_q == '0) begin
      n_bin = NBIN_W'(1);
    end else if (32'(bin_cfg_q) > 32'(MAX_BINS)) begin
      n_bin = NBIN_W'(MAX_BINS);
    end else begin
      n_bin = NBIN_W'(bin_cfg_q);
    end
  end

  // A counter at or past the last value counts as on it
  assign last_ch  = (32'(ch_cnt_q) + 32'd1) >= 32'(n_ch);
  assign last_bin = (32'(bin_cnt_q) + 32'd1) >= 32'(n_bin);
  assign last_src = (32'(src_cnt_q) + 32'd1) >= 32'(n_src);

  always_comb begin
    ch_cnt_d  = ch_cnt_q;
    bin_cnt_d = bin_cnt_q;
    src_cnt_d = src_cnt_q;
    if (adv_i) begin
      if (!last_ch) begin
        ch_cnt_d = ch_cnt_q + CH_W'(1);
      end else begin
        ch_cnt_d = '0;
        if (!last_bin) begin
          bin_cnt_d = bin_cnt_q + BIN_W'(1);
        end else begin
          bin_cnt_d = '0;
          src_cnt_d = last_src ? '0 : src_cnt_q + SRC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_cfg_q <= SRC_CFG_RST;
      ch_cfg_q  <= CH_CFG_RST;
      bin_cfg_q <= BIN_CFG_RST;
      ch_cnt_q  <= '0;
      bin_cnt_q <= '0;
      src_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_idx_i))
          CFG_SOURCES:  src_cfg_q <= cfg_data_i[SRC_CFG_W-1:0];
          CFG_CHANNELS: ch_cfg_q  <= cfg_data_i[CH_CFG_W-1:0];
          CFG_BINS:     bin_cfg_q <= cfg_data_i[BIN_CFG_W-1:0];
          default: ;
        endcase
      end
      ch_cnt_q  <= ch_cnt_d;
      bin_cnt_q <= bin_cnt_d;
      src_cnt_q <= src_cnt_d;
    end
  end

  assign seq_o.last_ch     = last_ch;
  assign seq_o.last_frame  = last_src && last_bin;
  assign seq_o.frame_start = (ch_cnt_q == '0) && (bin_cnt_q == '0) && (src_cnt_q == '0);
  assign seq_o.src_idx     = SRC_IDX_W'(src_cnt_q);
  assign seq_o.bin_idx     = BIN_IDX_W'(bin_cnt_q);

endmodule

[rtl/core/fdd_acc.sv]
// ----------------------------------------------------------------------------
// fdd_acc: complex multiply-accumulate
// Forms W*X from registered operands and adds it into the 37-bit running sum;
// the sum wraps modulo 2^37 and clears after the last channel of a bin.
// ----------------------------------------------------------------------------
module fdd_acc import fdd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic signed [SAMPLE_W-1:0] x_re_i,
  input  logic signed [SAMPLE_W-1:0] x_im_i,
  input  logic signed [SAMPLE_W-1:0] w_re_i,
  input  logic signed [SAMPLE_W-1:0] w_im_i,
  input  logic                       add_en_i,  // product contributes
  input  logic                       adv_i,     // stage 1 item consumed
  input  logic                       clr_i,     // last channel: restart sum
  output logic signed [SUM_W-1:0]    sum_re_o,  // sum including this item
  output logic signed [SUM_W-1:0]    sum_im_o
);

  logic signed [PROD_W-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [SUM_W-1:0]  term_re, term_im;
  logic signed [SUM_W-1:0]  sum_re_q, sum_im_q;

  assign p_rr = w_re_i * x_re_i;
  assign p_ii = w_im_i * x_im_i;
  assign p_ri = w_re_i * x_im_i;
  assign p_ir = w_im_i * x_re_i;

  assign term_re = add_en_i ? (SUM_W'(p_rr) - SUM_W'(p_ii)) : '0;
  assign term_im = add_en_i ? (SUM_W'(p_ri) + SUM_W'(p_ir)) : '0;

  assign sum_re_o = sum_re_q + term_re;
  assign sum_im_o = sum_im_q + term_im;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_re_q <= '0;
      sum_im_q <= '0;
    end else if (adv_i) begin
      sum_re_q <= clr_i ? '0 : sum_re_o;
      sum_im_q <= clr_i ? '0 : sum_im_o;
    end
  end

endmodule

[rtl/core/freq_domain_demix_mac.sv]
// ----------------------------------------------------------------------------
// freq_domain_demix_mac: frequency-domain demixing multiply-accumulate
// Weight-and-sum beamformer core: sums W*X over the enabled channels of each
// bin and emits one separated bin per source and bin.
// ----------------------------------------------------------------------------
// A request accepted on in_i is held in the operand register; when the final
// channel of a bin leaves it, the bin sum is loaded into the result register.
// Throughput: one request per cycle, set by the 37-bit accumulator loop fed by
// four parallel 16x16 multipliers; a final-channel item waits while out_o stalls.
// Reset: counters and sums clear, registers return to 4 sources, 4 channels,
// 257 bins; both pipeline stages empty.
// ----------------------------------------------------------------------------
module freq_domain_demix_mac import fdd_pkg::*; #(
  parameter int MAX_SOURCES  = DEF_MAX_SOURCES,
  parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
  parameter int MAX_BINS     = DEF_MAX_BINS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fdd_in_if.sink                in_i,
  fdd_out_if.source             out_o
);

  // Stage 1: operand register
  logic                       s1_v_q;
  logic signed [SAMPLE_W-1:0] x_re_q, x_im_q, w_re_q, w_im_q;
  logic                       en_q, act_q;

  // Stage 2: result register
  logic                        out_v_q;
  logic signed [SUM_W-1:0]     y_re_q, y_im_q;
  logic        [SRC_IDX_W-1:0] src_idx_q;
  logic        [BIN_IDX_W-1:0] bin_idx_q;
  logic                        last_frame_q;

  seq_t                    seq;
  logic                    s1_fire, in_fire, out_load;
  logic signed [SUM_W-1:0] sum_re, sum_im;

  // A non-final channel only updates the sum, so it always moves on; the
  // final channel needs room in the result register.
  assign s1_fire  = s1_v_q && (!seq.last_ch || !out_v_q || out_o.ready);
  assign out_load = s1_fire && seq.last_ch;
  assign in_i.ready = !s1_v_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;

  fdd_seq #(
    .MAX_SOURCES  (MAX_SOURCES),
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_BINS     (MAX_BINS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .adv_i      (s1_fire),
    .seq_o      (seq)
  );

  // Masked channels and inactive sources add nothing
  fdd_acc u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .x_re_i   (x_re_q),
    .x_im_i   (x_im_q),
    .w_re_i   (w_re_q),
    .w_im_i   (w_im_q),
    .add_en_i (en_q && act_q),
    .adv_i    (s1_fire),
    .clr_i    (seq.last_ch),
    .sum_re_o (sum_re),
    .sum_im_o (sum_im)
  );

  // Operand register: hold while the item waits, load on each request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      x_re_q <= in_i.x_re;
      x_im_q <= in_i.x_im;
      w_re_q <= in_i.w_re;
      w_im_q <= in_i.w_im;
      en_q   <= in_i.channel_enabled;
      act_q  <= in_i.source_active;
    end
  end

  // Result register: an inactive source on the final channel reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      y_re_q       <= act_q ? sum_re : '0;
      y_im_q       <= act_q ? sum_im : '0;
      src_idx_q    <= seq.src_idx;
      bin_idx_q    <= seq.bin_idx;
      last_frame_q <= seq.last_frame;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.y_re          = y_re_q;
  assign out_o.y_im          = y_im_q;
  assign out_o.source_index  = src_idx_q;
  assign out_o.bin_index     = bin_idx_q;
  assign out_o.last_of_frame = last_frame_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // The final result of a frame returns the sequencer to the frame start
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && seq.last_frame |=> seq.frame_start)
    else $error("sequencer did not return to frame start after last result");

  // A final-channel item blocked by a full, stalled result register stays put
  a_hold_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && seq.last_ch && out_v_q && !out_o.ready |=> s1_v_q && out_v_q)
    else $error("final-channel item left stage 1 while the result was stalled");

  // A new result only follows the final channel of a bin
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(s1_fire && seq.last_ch))
    else $error("result appeared without a final-channel item");

endmodule
